/* sv/kfe_pkg.sv */
// Package for the framed byte encoder: framing codes, check constants,
// shared item and burst types and the check update function.
// No dependencies.
package kfe_pkg;

   localparam logic [7:0]  FRAME_END  = 8'hC0;
   localparam logic [7:0]  FRAME_ESC  = 8'hDB;
   localparam logic [7:0]  TRANS_END  = 8'hDC;
   localparam logic [7:0]  TRANS_ESC  = 8'hDD;
   localparam logic [15:0] CHECK_INIT = 16'hFFFF;
   localparam logic [15:0] CHECK_POLY = 16'h8408;
   localparam logic [7:0]  BYTE_MASK  = 8'hFF;

   // Longest burst: marker, escaped byte, two escaped check bytes, marker.
   localparam int BURST_MAX = 8;
   localparam int CNT_W     = $clog2(BURST_MAX + 1);
   localparam int IDX_W     = $clog2(BURST_MAX);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       no_data;
   } item_type;

   // Output bytes of one item, entry 0 goes out first.
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      logic                      close;
   } burst_type;

   // Reflected CRC-16 update, LSB first.
   function automatic logic [15:0] check_update(input logic [15:0] crc_val,
                                                input logic [7:0]  b);
      logic [15:0] c;
      c = crc_val ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CHECK_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* sv/kfe_req_if.sv */
// Input channel: message byte with framing flags, valid/ready handshake.
// No dependencies.
interface kfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;
   logic       no_data;

   modport source (output valid, output data_byte, output first_byte,
                   output last_byte, output no_data, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input last_byte, input no_data, output ready);
endinterface

/* sv/kfe_rsp_if.sv */
// Result channel: one framed output byte per transfer, valid/ready handshake.
// No dependencies.
interface kfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_done;

   modport source (output valid, output out_byte, output run_last,
                   output frame_done, input ready);
   modport sink   (input valid, input out_byte, input run_last,
                   input frame_done, output ready);
endinterface

/* sv/kiss_frame_encoder_fcs16_unit.sv */
// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    data_byte[7:0], first_byte, last_byte, no_data
// rsp_ch    out  valid/ready    out_byte[7:0], run_last, frame_done
//
// Each item produces 1 to 8 result bytes (1 for a plain byte, 2 for an escaped
// one, up to 8 with marker and trailer); the output shift register sends one
// byte per cycle while rsp_ch.ready is high.
// The next item is taken into the input register while the current burst drains.
// Reset (synchronous, active high) empties both stages and sets the check to 0xFFFF.
// A stalled rsp_ch holds its byte; req_ch.ready drops once both stages are full.
module kiss_frame_encoder_fcs16_unit (
   input  logic    clock,
   input  logic    reset,
   kfe_req_if.sink req_ch,
   kfe_rsp_if.source rsp_ch
);
   import kfe_pkg::*;

   // Burst handoff between the builder and the serializer.
   logic      burst_valid;
   logic      burst_ready;
   burst_type burst;

   // Input register, running check and the combinational burst builder:
   // marker, escaped byte, escaped check bytes and closing marker are laid
   // out into a fixed 8-byte burst with a byte count.
   kfe_burst_build u_build (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .burst_valid (burst_valid),
      .burst       (burst),
      .burst_ready (burst_ready)
   );

   // Output register: shifts the burst out, one byte per accepted rsp_ch transfer.
   // It takes a new burst in the same cycle its last byte is taken.
   kfe_burst_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (burst),
      .burst_ready (burst_ready),
      .rsp_ch      (rsp_ch)
   );

`ifndef SYNTHESIS
   // A handed-off burst always carries between one and eight bytes.
   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      (burst_valid && burst_ready) |-> (burst.count != '0 &&
                                        burst.count <= CNT_W'(BURST_MAX)))
      else $error("burst count out of range");

   // The closing marker is always the final byte of its item.
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_done) |->
         (rsp_ch.run_last && rsp_ch.out_byte == FRAME_END))
      else $error("frame close not on final marker byte");

   // A burst cannot be replaced while bytes of the previous one still wait.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.run_last) |-> !burst_ready)
      else $error("burst accepted while output still busy");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");
`endif

endmodule

/* sv/kfe_burst_build.sv */
// Input register, running check register and burst builder.
// Depends on kfe_pkg and kfe_req_if.
module kfe_burst_build (
   input  logic              clock,
   input  logic              reset,
   kfe_req_if.sink           req_ch,
   output logic              burst_valid,
   output kfe_pkg::burst_type burst,
   input  logic              burst_ready
);
   import kfe_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   item_type    hold_item_ff;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_base, crc_new, fcs;
   logic        req_take, burst_take;

   function automatic burst_type put_byte(input burst_type bin, input logic [7:0] b);
      burst_type bout;
      bout = bin;
      bout.bytes[bin.count[IDX_W-1:0]] = b;
      bout.count = bin.count + CNT_W'(1);
      return bout;
   endfunction

   function automatic burst_type put_esc(input burst_type bin, input logic [7:0] b);
      burst_type bout;
      if (b == FRAME_END) begin
         bout = put_byte(put_byte(bin, FRAME_ESC), TRANS_END);
      end else if (b == FRAME_ESC) begin
         bout = put_byte(put_byte(bin, FRAME_ESC), TRANS_ESC);
      end else begin
         bout = put_byte(bin, b);
      end
      return bout;
   endfunction

   assign burst_take   = hold_valid_ff && burst_ready;
   assign req_ch.ready = !hold_valid_ff || burst_ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign burst_valid  = hold_valid_ff;

   always_comb begin
      crc_base = hold_item_ff.first_byte ? CHECK_INIT : crc_ff;
      crc_new  = check_update(crc_base, hold_item_ff.data_byte);
      fcs      = crc_new ^ CHECK_INIT;
   end

   always_comb begin
      burst = '0;
      if (hold_item_ff.no_data) begin
         // empty message: marker, zero check, marker
         burst = put_byte(burst, FRAME_END);
         burst = put_byte(burst, 8'h00);
         burst = put_byte(burst, 8'h00);
         burst = put_byte(burst, FRAME_END);
         burst.close = 1'b1;
      end else begin
         if (hold_item_ff.first_byte) begin
            burst = put_byte(burst, FRAME_END);
         end
         burst = put_esc(burst, hold_item_ff.data_byte);
         if (hold_item_ff.last_byte) begin
            burst = put_esc(burst, fcs[7:0] & BYTE_MASK);
            burst = put_esc(burst, fcs[15:8]);
            burst = put_byte(burst, FRAME_END);
            burst.close = 1'b1;
         end
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_take) begin
         hold_valid_in = 1'b1;
      end else if (burst_take) begin
         hold_valid_in = 1'b0;
      end
      crc_in = crc_ff;
      if (burst_take) begin
         if (hold_item_ff.no_data || hold_item_ff.last_byte) begin
            crc_in = CHECK_INIT;
         end else begin
            crc_in = crc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         crc_ff        <= CHECK_INIT;
      end else begin
         hold_valid_ff <= hold_valid_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_item_ff.data_byte  <= req_ch.data_byte;
         hold_item_ff.first_byte <= req_ch.first_byte;
         hold_item_ff.last_byte  <= req_ch.last_byte;
         hold_item_ff.no_data    <= req_ch.no_data;
      end
   end

endmodule

/* sv/kfe_burst_serial.sv */
// Output shift register: emits a burst one byte per accepted transfer on the result channel.
// Depends on kfe_pkg and kfe_rsp_if.
module kfe_burst_serial (
   input  logic              clock,
   input  logic              reset,
   input  logic              burst_valid,
   input  kfe_pkg::burst_type burst,
   output logic              burst_ready,
   kfe_rsp_if.source         rsp_ch
);
   import kfe_pkg::*;

   logic [BURST_MAX-1:0][7:0] shift_ff, shift_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      close_ff, close_in;
   logic                      pop, tail;

   assign tail        = (count_ff == CNT_W'(1));
   assign pop         = rsp_ch.valid && rsp_ch.ready;
   assign burst_ready = (count_ff == '0) || (tail && rsp_ch.ready);

   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.out_byte   = shift_ff[0];
   assign rsp_ch.run_last   = tail;
   assign rsp_ch.frame_done = tail && close_ff;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      close_in = close_ff;
      if (burst_valid && burst_ready) begin
         shift_in = burst.bytes;
         count_in = burst.count;
         close_in = burst.close;
      end else if (pop) begin
         shift_in = {8'h00, shift_ff[BURST_MAX-1:1]};
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      close_ff <= close_in;
   end

endmodule
